// ----- rtl/core/key_value_text_splitter_defines.svh -----
// assertion macros for the key/value text splitter
// used by the port checker; no other dependencies
`ifndef KEY_VALUE_TEXT_SPLITTER_DEFINES_SVH
`define KEY_VALUE_TEXT_SPLITTER_DEFINES_SVH

// clocked property, switched off while reset is low
`define KVTS_ASSERT(name, clock, rstn, prop, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error(msg);

// implication checked in the next cycle
`define KVTS_ASSERT_NEXT(name, clock, rstn, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/kvts_pkg.sv -----
// shared types and constants for the key/value text splitter
// no dependencies
package kvts_pkg;

	localparam int KEY_CAP    = 64;
	localparam int VALUE_CAP  = 64;
	localparam int KCNT_W     = $clog2(KEY_CAP);
	localparam int VCNT_W     = $clog2(VALUE_CAP);
	localparam int LEN_W      = $clog2(KEY_CAP);
	localparam int HOLD_DEPTH = 2 ** LEN_W;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		STREAM_KEY   = 2'd0,
		STREAM_VALUE = 2'd1,
		STREAM_END   = 2'd2
	} stream_t;

	typedef enum logic [1:0] {
		PH_GAP   = 2'd0,
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SRC_ZERO  = 2'd0,
		SRC_IN    = 2'd1,
		SRC_COMMA = 2'd2,
		SRC_HOLD  = 2'd3
	} char_src_t;

	typedef enum logic [1:0] {
		SQ_IDLE    = 2'd0,
		SQ_COMMA_K = 2'd1,
		SQ_COMMA_V = 2'd2,
		SQ_KEYS    = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		stream_t    stream;
		logic [7:0] out_char;
		logic       last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic             load_out;
		stream_t          stream;
		char_src_t        src;
		logic             last;
		logic             inc_key;
		logic             inc_value;
		logic             hold_clear;
		logic             hold_write;
		logic             hold_restart;
		logic             phase_we;
		phase_t           phase_next;
		logic             first_clear;
		logic             clear_all;
		logic [LEN_W-1:0] rd_addr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		phase_t           phase;
		logic             first_token;
		logic             is_space;
		logic             is_equal;
		logic             end_of_text;
		logic             key_room;
		logic             key_room2;
		logic             value_room;
		logic [LEN_W-1:0] hold_len;
		logic             out_free;
	} status_t;

endpackage

// ----- rtl/core/key_value_text_splitter.sv -----
// key/value text splitter: input character channel in, key and value stream out
// pairs kvts_ctrl with kvts_datapath; types from kvts_pkg
//
// Usage
//   item channel: one text character a item, end_of_text on the last one.
//   result channel: stream (key, value or end only), out_char and last.
//   both channels move an item at a clock edge with valid high, stall low.
// Throughput and sequencing
//   a character that gives at most one result is taken while the output is
//   free and its result shows in the output register on the next cycle;
//   one character a cycle is sustained through keys, values and spaces
//   while the receiver does not stall. a '=' that opens a token is taken,
//   then come the two comma steps, the key hold memory read of up to
//   KEY_CAP-1 bytes, one entry a cycle while the output is free, and a
//   closing step, all with input stalled and stretched by receiver stalls.
// Reset and stall
//   arst_n clears the token state and the output register at once; the
//   key hold memory needs no clearing pass, it is read only after writing.
//   while the receiver stalls, the result holds and input is stalled for as
//   long as the occupied output register is not taken.
module key_value_text_splitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  kvts_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output kvts_pkg::out_item_t result
);

	kvts_pkg::cmd_t    cmd;
	kvts_pkg::status_t status;

	kvts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.status     (status),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	kvts_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- rtl/core/kvts_datapath.sv -----
// datapath: token phase, stream counters, key hold memory, result register
// depends on kvts_pkg
module kvts_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  kvts_pkg::in_item_t  item,
	input  kvts_pkg::cmd_t      cmd,
	input  logic                result_stall,
	output kvts_pkg::status_t   status,
	output logic                result_valid,
	output kvts_pkg::out_item_t result
);

	kvts_pkg::phase_t                phase_q;
	logic                            first_q;
	logic [kvts_pkg::KCNT_W-1:0]     key_count_q;
	logic [kvts_pkg::VCNT_W-1:0]     value_count_q;
	logic [kvts_pkg::LEN_W-1:0]      hold_len_q;
	logic [7:0]                      hold_mem [kvts_pkg::HOLD_DEPTH];
	logic [7:0]                      rd_data_s1;
	logic                            out_valid_q;
	kvts_pkg::out_item_t             out_q;
	logic                            hold_room;
	logic                            wr_en;
	logic [kvts_pkg::LEN_W-1:0]      wr_addr;
	logic [7:0]                      out_char;

	// hold store write: restart puts the character at the head
	assign hold_room = int'(hold_len_q) < kvts_pkg::KEY_CAP - 1;
	assign wr_en     = cmd.hold_restart || (cmd.hold_write && hold_room);
	assign wr_addr   = cmd.hold_restart ? '0 : hold_len_q;

	// key hold memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hold_mem[wr_addr] <= item.character;
		end
		rd_data_s1 <= hold_mem[cmd.rd_addr];
	end

	// token state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= kvts_pkg::PH_GAP;
			first_q       <= 1'b1;
			key_count_q   <= '0;
			value_count_q <= '0;
			hold_len_q    <= '0;
		end else if (cmd.clear_all) begin
			phase_q       <= kvts_pkg::PH_GAP;
			first_q       <= 1'b1;
			key_count_q   <= '0;
			value_count_q <= '0;
			hold_len_q    <= '0;
		end else begin
			if (cmd.phase_we) begin
				phase_q <= cmd.phase_next;
			end
			if (cmd.first_clear) begin
				first_q <= 1'b0;
			end
			if (cmd.inc_key) begin
				key_count_q <= key_count_q + 1'b1;
			end
			if (cmd.inc_value) begin
				value_count_q <= value_count_q + 1'b1;
			end
			if (cmd.hold_clear) begin
				hold_len_q <= '0;
			end else if (cmd.hold_restart) begin
				hold_len_q <= kvts_pkg::LEN_W'(1);
			end else if (wr_en) begin
				hold_len_q <= hold_len_q + 1'b1;
			end
		end
	end

	// character source select
	always_comb begin
		case (cmd.src)
			kvts_pkg::SRC_IN:    out_char = item.character;
			kvts_pkg::SRC_COMMA: out_char = kvts_pkg::CH_COMMA;
			kvts_pkg::SRC_HOLD:  out_char = rd_data_s1;
			default:             out_char = 8'h00;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.stream   <= cmd.stream;
			out_q.out_char <= out_char;
			out_q.last     <= cmd.last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// status back to the controller
	assign status.phase       = phase_q;
	assign status.first_token = first_q;
	assign status.is_space    = item.character == kvts_pkg::CH_SPACE;
	assign status.is_equal    = item.character == kvts_pkg::CH_EQUAL;
	assign status.end_of_text = item.end_of_text;
	assign status.key_room    = int'(key_count_q) < kvts_pkg::KEY_CAP - 1;
	assign status.key_room2   = int'(key_count_q) < kvts_pkg::KEY_CAP - 2;
	assign status.value_room  = int'(value_count_q) < kvts_pkg::VALUE_CAP - 1;
	assign status.hold_len    = hold_len_q;
	assign status.out_free    = !out_valid_q || !result_stall;

endmodule

// ----- rtl/core/kvts_ctrl.sv -----
// controller: takes items and sequences commas and held key bytes
// depends on kvts_pkg
module kvts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  kvts_pkg::status_t status,
	output logic              item_stall,
	output kvts_pkg::cmd_t    cmd
);

	kvts_pkg::seq_state_t       state_q, state_d;
	logic [kvts_pkg::LEN_W-1:0] idx_q, idx_d;
	logic                       eot_q, eot_d;
	logic                       emitted_q, emitted_d;
	logic                       can_emit;
	logic                       open_tok;
	logic                       hold_nz;
	logic                       more_keys;
	logic                       next_lt;

	assign can_emit  = status.out_free;
	assign hold_nz   = status.hold_len != '0;
	assign more_keys = (idx_q < status.hold_len) && status.key_room;
	assign next_lt   = ({1'b0, idx_q} + 1'b1) < {1'b0, status.hold_len};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kvts_pkg::SQ_IDLE;
			idx_q     <= '0;
			eot_q     <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			eot_q     <= eot_d;
			emitted_q <= emitted_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		eot_d      = eot_q;
		emitted_d  = emitted_q;
		cmd        = '0;
		item_stall = 1'b1;
		open_tok   = 1'b0;
		unique case (state_q)
			kvts_pkg::SQ_IDLE: begin
				item_stall = !can_emit;
				idx_d      = '0;
				if (item_valid && can_emit) begin
					unique case (status.phase)
						kvts_pkg::PH_KEY: begin
							if (status.is_space) begin
								cmd.hold_clear = 1'b1;
								cmd.phase_we   = 1'b1;
								cmd.phase_next = kvts_pkg::PH_GAP;
							end else if (status.is_equal) begin
								open_tok = 1'b1;
							end else begin
								cmd.hold_write = 1'b1;
							end
						end
						kvts_pkg::PH_VALUE: begin
							if (status.is_space) begin
								cmd.phase_we   = 1'b1;
								cmd.phase_next = kvts_pkg::PH_GAP;
							end else if (status.value_room) begin
								cmd.load_out  = 1'b1;
								cmd.stream    = kvts_pkg::STREAM_VALUE;
								cmd.src       = kvts_pkg::SRC_IN;
								cmd.inc_value = 1'b1;
							end
						end
						default: begin
							// between tokens, and the unused code
							cmd.phase_we   = 1'b1;
							cmd.phase_next = kvts_pkg::PH_GAP;
							if (status.is_space) begin
								cmd.phase_we = 1'b1;
							end else if (status.is_equal) begin
								cmd.hold_clear = 1'b1;
								open_tok       = 1'b1;
							end else begin
								cmd.hold_restart = 1'b1;
								cmd.phase_next   = kvts_pkg::PH_KEY;
							end
						end
					endcase
					if (open_tok) begin
						state_d   = kvts_pkg::SQ_COMMA_K;
						eot_d     = status.end_of_text;
						emitted_d = 1'b0;
					end else if (status.end_of_text) begin
						// end of text: flag the last item, end-only if none
						cmd.clear_all = 1'b1;
						if (!cmd.load_out) begin
							cmd.load_out = 1'b1;
							cmd.stream   = kvts_pkg::STREAM_END;
							cmd.src      = kvts_pkg::SRC_ZERO;
						end
						cmd.last = 1'b1;
					end
				end
			end
			kvts_pkg::SQ_COMMA_K: begin
				idx_d = '0;
				if (!status.first_token && status.key_room) begin
					if (can_emit) begin
						cmd.load_out = 1'b1;
						cmd.stream   = kvts_pkg::STREAM_KEY;
						cmd.src      = kvts_pkg::SRC_COMMA;
						cmd.inc_key  = 1'b1;
						cmd.last     = eot_q && !status.value_room
							&& !(hold_nz && status.key_room2);
						emitted_d    = 1'b1;
						state_d      = kvts_pkg::SQ_COMMA_V;
					end
				end else begin
					state_d = kvts_pkg::SQ_COMMA_V;
				end
			end
			kvts_pkg::SQ_COMMA_V: begin
				idx_d = '0;
				if (!status.first_token && status.value_room) begin
					if (can_emit) begin
						cmd.load_out  = 1'b1;
						cmd.stream    = kvts_pkg::STREAM_VALUE;
						cmd.src       = kvts_pkg::SRC_COMMA;
						cmd.inc_value = 1'b1;
						cmd.last      = eot_q && !(hold_nz && status.key_room);
						emitted_d     = 1'b1;
						state_d       = kvts_pkg::SQ_KEYS;
					end
				end else begin
					state_d = kvts_pkg::SQ_KEYS;
				end
			end
			kvts_pkg::SQ_KEYS: begin
				if (more_keys) begin
					// release one held key byte a cycle while the output is free
					if (can_emit) begin
						cmd.load_out = 1'b1;
						cmd.stream   = kvts_pkg::STREAM_KEY;
						cmd.src      = kvts_pkg::SRC_HOLD;
						cmd.inc_key  = 1'b1;
						cmd.last     = eot_q && !(next_lt && status.key_room2);
						idx_d        = idx_q + 1'b1;
						emitted_d    = 1'b1;
					end
				end else if (!(eot_q && !emitted_q && !can_emit)) begin
					// token open: move to the value part
					cmd.hold_clear  = 1'b1;
					cmd.first_clear = 1'b1;
					cmd.phase_we    = 1'b1;
					cmd.phase_next  = kvts_pkg::PH_VALUE;
					if (eot_q) begin
						cmd.clear_all = 1'b1;
						if (!emitted_q) begin
							cmd.load_out = 1'b1;
							cmd.stream   = kvts_pkg::STREAM_END;
							cmd.src      = kvts_pkg::SRC_ZERO;
							cmd.last     = 1'b1;
						end
					end
					idx_d   = '0;
					state_d = kvts_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = kvts_pkg::SQ_IDLE;
			end
		endcase
		cmd.rd_addr = idx_d;
	end

endmodule

// ----- rtl/core/kvts_checker.sv -----
// port checker for the key/value text splitter, bound to the top level
// depends on kvts_pkg and key_value_text_splitter_defines.svh
`include "key_value_text_splitter_defines.svh"

module kvts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input kvts_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_stall,
	input kvts_pkg::out_item_t result
);

	// a stalled result item holds
	`KVTS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// end-only item carries no character and closes the text
	`KVTS_ASSERT(a_end_only, clk, arst_n, result_valid && result.stream == kvts_pkg::STREAM_END |-> result.out_char == 8'h00 && result.last, "bad end-only item")

	// a space inside the text never yields a new result
	`KVTS_ASSERT_NEXT(a_space_quiet, clk, arst_n, item_valid && !item_stall && item.character == kvts_pkg::CH_SPACE && !item.end_of_text, !result_valid || $past(result_valid && result_stall), "space gave a result")

	// an end of text taken on a space always gives a last result in the next cycle
	`KVTS_ASSERT_NEXT(a_eot_space, clk, arst_n, item_valid && !item_stall && item.end_of_text && item.character == kvts_pkg::CH_SPACE, result_valid && result.last, "end of text not flagged")

endmodule

bind key_value_text_splitter kvts_checker u_checker (.*);
